/* sv/fibmp_pkg.sv */
package fibmp_pkg;

  // word width of every value, kept modulo 2^FIB_W
  localparam int FIB_W   = 16;
  // multiplier digit consumed by each lane per cycle
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = FIB_W / DIGIT_W;
  localparam int DCNT_W  = $clog2(DIGITS);
  // parallel digit-serial multiply lanes
  localparam int LANES   = 7;

  // default index width
  localparam int INDEX_BITS_DEF = 32;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_FLUSH
  } fib_state_t;

  typedef logic [FIB_W-1:0] fib_word_t;

endpackage

/* sv/fibonacci_mod_2_16_matrix_power.sv */
// channel | ports                                  | direction | word
// --------+----------------------------------------+-----------+------------------------
// in      | in_valid, in_stall, in_index[31:0]     | input     | fibonacci index n
// out     | out_valid, out_stall, out_fib_value    | output    | F(n) mod 65536, 16 bits
//
// one word at a time: accept, then for each index bit up to the highest set bit
// a setup state and a multiply state in which the seven multiply lanes take in
// all DIGITS=4 multiplier digits, then a hand-over from the flush state to the
// output register
// rst_n is synchronous, active low; it clears the sequencer and the output valid
// out_stall only holds the output register; a finished word waits in the flush
// state while the previous result is still stalled, and in_stall stays high until
// the sequencer is back in idle
module fibonacci_mod_2_16_matrix_power #(
  parameter int INDEX_BITS = fibmp_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [fibmp_pkg::FIB_W-1:0] out_fib_value
);
  import fibmp_pkg::*;

  // lane assignment for one bit step
  // the power Q^k is held as the pair a = F(k), b = F(k+1)
  // the accumulator Q^m as c = F(m), d = F(m+1)
  localparam int L_ASQ = 0;  // a * (2b - a)
  localparam int L_AA  = 1;  // a * a
  localparam int L_BB  = 2;  // b * b
  localparam int L_CB  = 3;  // c * b
  localparam int L_DA  = 4;  // d * a
  localparam int L_CA  = 5;  // c * a
  localparam int L_DB  = 6;  // d * b

  fib_state_t state_r, state_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [INDEX_BITS-1:0] rem_r;
  fib_word_t a_r, b_r, c_r, d_r;
  fib_word_t x_r [LANES];
  fib_word_t y_r [LANES];
  fib_word_t s_r [LANES];
  fib_word_t s_nxt [LANES];
  fib_word_t out_val_r;
  logic out_valid_r, out_valid_nxt;

  logic in_acc, lane_load, lane_run, step_done, out_load, rem_zero, last_digit;

  assign in_acc     = in_valid && !in_stall;
  assign rem_zero   = (rem_r == '0);
  assign last_digit = (dcnt_r == DCNT_W'(DIGITS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = rem_zero ? ST_FLUSH : ST_MUL;
      ST_MUL:   if (last_digit) state_nxt = ST_SETUP;
      ST_FLUSH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    lane_load = 1'b0;
    lane_run  = 1'b0;
    step_done = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SETUP: lane_load = !rem_zero;
      ST_MUL: begin
        lane_run  = 1'b1;
        step_done = last_digit;
      end
      ST_FLUSH: out_load = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  // digit counter
  always_comb begin
    dcnt_nxt = dcnt_r;
    if (lane_load) dcnt_nxt = '0;
    else if (lane_run) dcnt_nxt = dcnt_r + DCNT_W'(1);
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // lane partial sums: one digit of the multiplier per cycle in the multiply state, low bits only
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s_nxt[i] = s_r[i] + x_r[i] * FIB_W'(y_r[i][DIGIT_W-1:0]);
    end
  end

  // lane shift registers
  always_ff @(posedge clk) begin
    if (lane_load) begin
      x_r[L_ASQ] <= a_r;  y_r[L_ASQ] <= (b_r << 1) - a_r;
      x_r[L_AA]  <= a_r;  y_r[L_AA]  <= a_r;
      x_r[L_BB]  <= b_r;  y_r[L_BB]  <= b_r;
      x_r[L_CB]  <= c_r;  y_r[L_CB]  <= b_r;
      x_r[L_DA]  <= d_r;  y_r[L_DA]  <= a_r;
      x_r[L_CA]  <= c_r;  y_r[L_CA]  <= a_r;
      x_r[L_DB]  <= d_r;  y_r[L_DB]  <= b_r;
      for (int i = 0; i < LANES; i++) s_r[i] <= '0;
    end else if (lane_run) begin
      for (int i = 0; i < LANES; i++) begin
        x_r[i] <= x_r[i] << DIGIT_W;
        y_r[i] <= y_r[i] >> DIGIT_W;
        s_r[i] <= s_nxt[i];
      end
    end
  end

  // load on accept; power squaring, conditional accumulate and index shift at the end of a step
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rem_r <= INDEX_BITS'(in_index);
      a_r   <= fib_word_t'(1);
      b_r   <= fib_word_t'(1);
      c_r   <= '0;
      d_r   <= fib_word_t'(1);
    end else if (step_done) begin
      rem_r <= rem_r >> 1;
      a_r   <= s_nxt[L_ASQ];
      b_r   <= s_nxt[L_AA] + s_nxt[L_BB];
      if (rem_r[0]) begin
        c_r <= s_nxt[L_CB] + s_nxt[L_DA] - s_nxt[L_CA];
        d_r <= s_nxt[L_DB] + s_nxt[L_CA];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) out_val_r <= c_r;
  end

  assign out_valid     = out_valid_r;
  assign out_fib_value = out_val_r;

  // accepted word always starts with a setup cycle
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SETUP)
    else $error("accepted word did not enter setup");

  // an exhausted index goes straight to the output hand-over
  a_zero_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP && rem_zero) |=> state_r == ST_FLUSH)
    else $error("exhausted index did not flush");

  // digit counter runs only inside the multiply phase
  a_dcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FLUSH) |-> dcnt_r == '0)
    else $error("digit counter left nonzero");

  // a new result appears only from the flush state
  a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FLUSH)
    else $error("result raised outside flush");

endmodule

/* tb/sv/fibonacci_mod_2_16_matrix_power_checker.sv */
module fibonacci_mod_2_16_matrix_power_checker #(
  parameter int INDEX_BITS = fibmp_pkg::INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [31:0]          in_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  fibmp_pkg::fib_word_t out_fib_value,
  output int                   pending,
  output int                   errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import fibmp_pkg::*;

  localparam int MAX_PRINTED = 40;

  // row-major 2x2 matrix, entry [0] = top left
  typedef logic [3:0][FIB_W-1:0] mat2x2_t;

  fib_word_t   fib_expected_q[$];
  logic [31:0] index_q[$];

  // 2x2 product, every entry wraps at 16 bits
  function automatic mat2x2_t mat_mul16(input mat2x2_t x, input mat2x2_t y);
    mat2x2_t     r;
    logic [31:0] p;
    p = x[0] * y[0] + x[1] * y[2];
    r[0] = p[FIB_W-1:0];
    p = x[0] * y[1] + x[1] * y[3];
    r[1] = p[FIB_W-1:0];
    p = x[2] * y[0] + x[3] * y[2];
    r[2] = p[FIB_W-1:0];
    p = x[2] * y[1] + x[3] * y[3];
    r[3] = p[FIB_W-1:0];
    return r;
  endfunction

  // fibonacci of idx modulo 65536 by square-and-multiply over INDEX_BITS bits
  function automatic fib_word_t fib_mod16(input logic [31:0] idx);
    mat2x2_t     acc;
    mat2x2_t     pw;
    logic [63:0] bits;
    bits = {32'd0, idx};
    if (INDEX_BITS < 64) bits &= (64'd1 << INDEX_BITS) - 64'd1;
    acc = {16'd1, 16'd0, 16'd0, 16'd1};
    pw  = {16'd1, 16'd1, 16'd1, 16'd0};
    for (int k = 0; k < INDEX_BITS; k++) begin
      if (bits[0]) acc = mat_mul16(acc, pw);
      pw = mat_mul16(pw, pw);
      bits >>= 1;
    end
    return acc[1];
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    pending = 0;
    errors  = 0;
  end

  // result words are checked before the new index is queued
  always @(posedge clk) begin : watch
    fib_word_t   want;
    logic [31:0] idx;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (fib_expected_q.size() == 0) begin
          report_mismatch($sformatf("result word %0d with nothing expected", out_fib_value));
        end else begin
          want = fib_expected_q.pop_front();
          idx  = index_q.pop_front();
          if (out_fib_value !== want)
            report_mismatch($sformatf("index %0d: fib_value %0d, expected %0d",
                                      idx, out_fib_value, want));
        end
      end
      if (in_valid && !in_stall) begin
        fib_expected_q.push_back(fib_mod16(in_index));
        index_q.push_back(in_index);
      end
      pending = fib_expected_q.size();
    end
  end

endmodule

/* tb/sv/fibonacci_mod_2_16_matrix_power_tb.sv */
module fibonacci_mod_2_16_matrix_power_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fibmp_pkg::*;

  localparam int N_RANDOM      = 1330;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int N_DIRECTED    = 22;

  localparam logic [31:0] DIRECTED_INDEX [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd24, 32'd25, 32'd46,
    32'd47, 32'd100, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678,
    32'hDEAD_BEEF
  };

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_LONG
  } stall_mode_t;

  typedef enum int {
    SHAPE_SMALL,
    SHAPE_FULL,
    SHAPE_NARROW,
    SHAPE_ONEHOT,
    SHAPE_ONES
  } index_shape_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_index;
  logic        out_valid;
  logic        out_stall;
  fib_word_t   out_fib_value;
  int          pending;
  int          errors;
  int          burst_left;

  fibonacci_mod_2_16_matrix_power dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_fib_value (out_fib_value)
  );

  fibonacci_mod_2_16_matrix_power_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_fib_value (out_fib_value),
    .pending       (pending),
    .errors        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stall pattern, switching mode after each segment of random length
  initial begin : receiver
    stall_mode_t mode;
    int          seg_len;
    int          run_len;
    out_stall = 1'b0;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(50, 600);
      run_len = $urandom_range(4, 40);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= (k % (run_len + 4)) < run_len;
        endcase
      end
    end
  end

  // ends the run when no word moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one index word, hold it until taken, then maybe idle between bursts
  task automatic send_index(input logic [31:0] idx);
    int gap;
    in_index <= idx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_index <= $urandom;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // hold off the sender until every result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0]  idx;
    index_shape_t shape;
    in_valid   = 1'b0;
    in_index   = 32'd0;
    rst_n      = 1'b0;
    burst_left = 1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: small indices, wrap point, bit extremes
    for (int i = 0; i < N_DIRECTED; i++) send_index(DIRECTED_INDEX[i]);
    drain_results();

    // random indices of mixed shapes
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) drain_results();
      shape = index_shape_t'($urandom_range(0, 4));
      case (shape)
        SHAPE_SMALL:  idx = $urandom_range(0, 200);
        SHAPE_FULL:   idx = $urandom;
        SHAPE_NARROW: idx = $urandom >> $urandom_range(0, 31);
        SHAPE_ONEHOT: idx = 32'd1 << $urandom_range(0, 31);
        default: begin
          idx = 32'hFFFF_FFFF >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) idx = ~(32'd1 << $urandom_range(0, 31));
        end
      endcase
      send_index(idx);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
